/* sv/lzwc_pkg.sv */
// ----------------------------------------------------------------------------
// LZW compressor package
// Shared sequencer state type and fixed constants.
// ----------------------------------------------------------------------------
package lzwc_pkg;

   // first code handed out to a learned string
   localparam int unsigned FIRST_LEARNED = 256;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_HEAD = 5'b00010,
      S_NODE = 5'b00100,
      S_MISS = 5'b01000,
      S_FIN  = 5'b10000
   } state_type;

endpackage

/* sv/lzwc_fifo.sv */
// ----------------------------------------------------------------------------
// LZW compressor two-entry queue
// Small register queue; decouples producer and consumer by one stall.
// ----------------------------------------------------------------------------
module lzwc_fifo #(
   parameter int WIDTH = 9
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             not_empty
);
   import lzwc_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* sv/lzwc_engine.sv */
// ----------------------------------------------------------------------------
// LZW compressor engine
// Walks the child lists of the dictionary, learns pairs, emits codes.
// ----------------------------------------------------------------------------
module lzwc_engine #(
   parameter int DICT_ENTRIES = 4096,
   parameter int CODE_BITS    = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_avail,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 in_pop,
   input  logic                 out_full,
   output logic                 out_push,
   output logic [CODE_BITS-1:0] out_code,
   output logic                 out_final
);
   import lzwc_pkg::*;

   localparam int CW   = CODE_BITS;
   localparam int CAP  = (DICT_ENTRIES < (1 << CODE_BITS)) ? DICT_ENTRIES : (1 << CODE_BITS);
   localparam int AW   = $clog2(CAP);
   localparam int NW   = 2 * CW + 9;
   localparam logic [CW:0] CAP_C   = (CW+1)'(CAP);
   localparam logic [CW:0] FIRST_C = (CW+1)'(FIRST_LEARNED);

   // head: newest child of each code; node: {prefix, byte, sibling, sibling valid}
   logic [CW-1:0] head_mem [CAP];
   logic [NW-1:0] node_mem [CAP];
   logic [CW-1:0] head_q;
   logic [NW-1:0] node_q;

   state_type     state_ff, state_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          have_ff, have_in;
   logic [CW:0]   nfc_ff, nfc_in;
   logic [7:0]    byte_ff, byte_in;
   logic          last_ff, last_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          chk_ff, chk_in;
   logic [CW-1:0] hd_ff, hd_in;
   logic          hdok_ff, hdok_in;

   logic          head_rd, node_rd, learn;
   logic [AW-1:0] head_addr, node_addr;

   logic [CW-1:0] n_prefix, n_sib;
   logic [7:0]    n_byte;
   logic          n_sibv;

   assign {n_prefix, n_byte, n_sib, n_sibv} = node_q;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      have_in   = have_ff;
      nfc_in    = nfc_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      ptr_in    = ptr_ff;
      chk_in    = chk_ff;
      hd_in     = hd_ff;
      hdok_in   = hdok_ff;
      in_pop    = 1'b0;
      out_push  = 1'b0;
      out_code  = cur_ff;
      out_final = 1'b0;
      head_rd   = 1'b0;
      node_rd   = 1'b0;
      learn     = 1'b0;
      head_addr = cur_ff[AW-1:0];
      node_addr = hd_ff[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (in_avail) begin
               in_pop  = 1'b1;
               byte_in = in_byte;
               last_in = in_last;
               if (!have_ff) begin
                  cur_in   = CW'(in_byte);
                  have_in  = 1'b1;
                  state_in = S_FIN;
               end else begin
                  head_rd  = 1'b1;
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            hd_in = head_q;
            if ((head_q > cur_ff) && ({1'b0, head_q} < nfc_ff)) begin
               hdok_in   = 1'b1;
               node_rd   = 1'b1;
               node_addr = head_q[AW-1:0];
               ptr_in    = head_q;
               chk_in    = 1'b1;
               state_in  = S_NODE;
            end else begin
               hdok_in  = 1'b0;
               state_in = S_MISS;
            end
         end
         S_NODE: begin
            if (chk_ff && (n_prefix != cur_ff)) begin
               // stale head from an earlier stream
               hdok_in  = 1'b0;
               state_in = S_MISS;
            end else if (n_byte == byte_ff) begin
               cur_in   = ptr_ff;
               state_in = S_FIN;
            end else if (n_sibv) begin
               ptr_in    = n_sib;
               node_rd   = 1'b1;
               node_addr = n_sib[AW-1:0];
               chk_in    = 1'b0;
            end else begin
               state_in = S_MISS;
            end
         end
         S_MISS: begin
            if (!out_full) begin
               out_push = 1'b1;
               if (nfc_ff < CAP_C) begin
                  learn  = 1'b1;
                  nfc_in = nfc_ff + 1'b1;
               end
               cur_in   = CW'(byte_ff);
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!out_full) begin
               out_push  = 1'b1;
               out_final = 1'b1;
               have_in   = 1'b0;
               cur_in    = '0;
               nfc_in    = FIRST_C;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cur_ff   <= '0;
         have_ff  <= 1'b0;
         nfc_ff   <= FIRST_C;
      end else begin
         state_ff <= state_in;
         cur_ff   <= cur_in;
         have_ff  <= have_in;
         nfc_ff   <= nfc_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      ptr_ff  <= ptr_in;
      chk_ff  <= chk_in;
      hd_ff   <= hd_in;
      hdok_ff <= hdok_in;
   end

   always_ff @(posedge clock) begin
      if (learn) begin
         head_mem[cur_ff[AW-1:0]] <= nfc_ff[CW-1:0];
      end
      if (head_rd) begin
         head_q <= head_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (learn) begin
         node_mem[nfc_ff[AW-1:0]] <= {cur_ff, byte_ff, hd_ff, hdok_ff};
      end
      if (node_rd) begin
         node_q <= node_mem[node_addr];
      end
   end

endmodule

/* sv/lzw_byte_compressor.sv */
// ----------------------------------------------------------------------------
// LZW byte compressor
// Byte stream in, dictionary codes out, bounded dictionary.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one byte per transaction, req_end_of_input on the last
//    byte of a stream. A two-entry queue takes bytes while the engine works.
//  - rsp_ channel: emitted codes; rsp_final_code marks the closing code of a
//    stream. A two-entry queue holds results, so a stalled receiver only
//    stops the engine once both entries are taken.
//  - For each byte the engine reads the head memory, then walks the current
//    code's child list, one entry at a time, through the node memory's
//    single read port; a list holds at most 256 entries. A miss or a stale
//    list head ends the walk in the miss state. The first byte of a stream
//    needs no lookup.
//  - A miss code is pushed toward rsp_ from the miss state, after the list
//    walk; a closing code follows from the final state, also straight after
//    a single opening byte. A full result queue stalls the engine.
//  - Reset empties both queues, closes the string and frees all learned
//    codes; no clearing pass is needed, stale list heads are detected.
//  - A stream's end also empties the dictionary, the next byte opens afresh.
// ----------------------------------------------------------------------------
module lzw_byte_compressor #(
   parameter int DICT_ENTRIES = 4096,
   parameter int CODE_BITS    = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_input,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CODE_BITS-1:0] rsp_code,
   output logic                 rsp_final_code
);
   import lzwc_pkg::*;

   logic                 in_full, in_avail, in_pop;
   logic [8:0]           in_data;
   logic                 out_full, out_push, out_final;
   logic [CODE_BITS-1:0] out_code;

   assign req_ready = !in_full;

   // front: byte queue
   lzwc_fifo #(.WIDTH(9)) u_in_q (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data ({req_end_of_input, req_data_byte}),
      .full      (in_full),
      .pop       (in_pop),
      .pop_data  (in_data),
      .not_empty (in_avail)
   );

   // back: dictionary engine
   lzwc_engine #(.DICT_ENTRIES(DICT_ENTRIES), .CODE_BITS(CODE_BITS)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .in_avail  (in_avail),
      .in_byte   (in_data[7:0]),
      .in_last   (in_data[8]),
      .in_pop    (in_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_code  (out_code),
      .out_final (out_final)
   );

   // result queue
   lzwc_fifo #(.WIDTH(CODE_BITS + 1)) u_out_q (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data ({out_final, out_code}),
      .full      (out_full),
      .pop       (rsp_ready),
      .pop_data  ({rsp_final_code, rsp_code}),
      .not_empty (rsp_valid)
   );

   // engine never pushes into a full result queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_push |-> !out_full) else $error("result queue overrun");

   // engine only takes a byte that is there
   a_no_underrun: assert property (@(posedge clock) disable iff (reset)
      in_pop |-> in_avail) else $error("byte queue underrun");

   // nothing is offered straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result after reset");

endmodule

/* verif/lzw_byte_compressor_test.sv */
// ----------------------------------------------------------------------------
// LZW byte compressor test
// Random and directed byte streams are pushed through the compressor, and
// every code it returns is checked against a dictionary model kept here.
// ----------------------------------------------------------------------------
module lzw_byte_compressor_test;

   import lzwc_pkg::FIRST_LEARNED;

   localparam int DICT_ENTRIES = 4096;
   localparam int CODE_BITS    = 12;
   localparam int CAPACITY     = (DICT_ENTRIES < (1 << CODE_BITS)) ?
                                 DICT_ENTRIES : (1 << CODE_BITS);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_input;
   } byte_item_type;

   typedef struct packed {
      logic [CODE_BITS-1:0] code;
      logic                 final_code;
   } code_item_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [7:0]           req_data_byte = '0;
   logic                 req_end_of_input = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [CODE_BITS-1:0] rsp_code;
   logic                 rsp_final_code;

   lzw_byte_compressor #(
      .DICT_ENTRIES(DICT_ENTRIES),
      .CODE_BITS   (CODE_BITS)
   ) uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code        (rsp_code),
      .rsp_final_code  (rsp_final_code)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // dictionary model: string code, open flag and learned pairs
   logic [CODE_BITS-1:0] string_code;
   logic                 string_open;
   int unsigned          free_code;
   logic [CODE_BITS-1:0] pair_prefix [CAPACITY];
   logic [7:0]           pair_byte   [CAPACITY];

   byte_item_type  pending_bytes [$];
   code_item_type  expected_codes [$];
   int             mismatches = 0;
   bit             quiet_tx = 1'b0;    // sender hold-off until all codes are back
   bit             hold_go = 1'b0;     // starts the receiver long stall
   bit             rx_stall = 1'b0;    // receiver long stall in progress
   bit             steady = 1'b0;      // stretch with no idling on either side

   task automatic report(input string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   function automatic void compress_byte(input byte_item_type b);
      int found;
      code_item_type c;
      found = -1;
      if (!string_open) begin
         string_code = CODE_BITS'(b.data_byte);
         string_open = 1'b1;
      end else begin
         for (int k = FIRST_LEARNED; k < free_code; k++)
            if (found < 0 && pair_prefix[k] == string_code && pair_byte[k] == b.data_byte)
               found = k;
         if (found >= 0) begin
            string_code = CODE_BITS'(found);
         end else begin
            c.code = string_code;
            c.final_code = 1'b0;
            expected_codes.push_back(c);
            if (free_code < CAPACITY) begin
               pair_prefix[free_code] = string_code;
               pair_byte[free_code]   = b.data_byte;
               free_code++;
            end
            string_code = CODE_BITS'(b.data_byte);
         end
      end
      if (b.end_of_input) begin
         c.code = string_code;
         c.final_code = 1'b1;
         expected_codes.push_back(c);
         string_open = 1'b0;
         string_code = '0;
         free_code = FIRST_LEARNED;
      end
   endfunction

   function automatic void queue_byte(input logic [7:0] d, input logic e);
      byte_item_type b;
      b.data_byte = d;
      b.end_of_input = e;
      pending_bytes.push_back(b);
   endfunction

   // stream of n bytes drawn from an alphabet of the given size; small ones make strings repeat
   task automatic queue_stream(input int n, input int alphabet);
      logic [7:0] base;
      base = 8'($urandom);
      for (int i = 0; i < n; i++)
         queue_byte(base ^ 8'($urandom_range(0, alphabet - 1)), i == n - 1);
   endtask

   // driver: valid held with a steady payload until accepted
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            compress_byte('{req_data_byte, req_end_of_input});
            void'(pending_bytes.pop_front());
         end
         if (req_valid && !req_ready) begin
            // hold
         end else if (pending_bytes.size() > 0 &&
                      !quiet_tx && (steady || $urandom_range(0, 99) >= 6)) begin
            req_valid        <= 1'b1;
            req_data_byte    <= pending_bytes[0].data_byte;
            req_end_of_input <= pending_bytes[0].end_of_input;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver long stall, counted in cycles
   initial begin
      wait (hold_go);
      @(posedge clock);
      rx_stall <= 1'b1;
      repeat (300) @(posedge clock);
      rx_stall <= 1'b0;
   end

   // monitor: checks each accepted code against the oldest expectation
   always @(posedge clock) begin
      code_item_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_codes.size() == 0) begin
               report($sformatf("unexpected code %0d final %0b", rsp_code, rsp_final_code));
            end else begin
               want = expected_codes.pop_front();
               if (rsp_code !== want.code)
                  report($sformatf("code %0d, wanted %0d", rsp_code, want.code));
               if (rsp_final_code !== want.final_code)
                  report($sformatf("final flag %0b, wanted %0b", rsp_final_code,
                                   want.final_code));
            end
         end
         if (rx_stall) begin
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= steady || ($urandom_range(0, 99) >= 6);
         end
      end
   end

   initial begin
      string_open = 1'b0;
      string_code = '0;
      free_code   = FIRST_LEARNED;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: single-byte streams at the extremes, repeats, miss chains
      queue_byte(8'h00, 1'b1);
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'hAA, 1'b0); queue_byte(8'hAA, 1'b1);
      queue_byte(8'h55, 1'b0); queue_byte(8'h55, 1'b0); queue_byte(8'h55, 1'b0);
      queue_byte(8'h55, 1'b0); queue_byte(8'h55, 1'b1);
      queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0); queue_byte(8'h00, 1'b0); queue_byte(8'hFF, 1'b1);
      queue_byte(8'h01, 1'b0); queue_byte(8'h80, 1'b0); queue_byte(8'h7F, 1'b1);
      wait (pending_bytes.size() == 0 && expected_codes.size() == 0);

      // receiver holds off while the sender keeps offering bytes
      hold_go = 1'b1;
      queue_stream(40, 4);
      wait (pending_bytes.size() == 0 && expected_codes.size() == 0);

      // sender pauses mid-stream until every expected code is back
      queue_stream(10, 3);
      wait (pending_bytes.size() == 5);
      quiet_tx = 1'b1;
      wait (expected_codes.size() == 0);
      repeat (5) @(posedge clock);
      quiet_tx = 1'b0;
      wait (pending_bytes.size() == 0 && expected_codes.size() == 0);

      // longer stream: many learned codes from a wide alphabet
      queue_stream(150, 256);
      wait (pending_bytes.size() == 0 && expected_codes.size() == 0);

      // random streams, mostly short, with a no-idle stretch in the middle
      for (int s = 0; s < 60; s++) begin
         if (s == 20) steady = 1'b1;
         if (s == 30) steady = 1'b0;
         queue_stream($urandom_range(1, 30), $urandom_range(1, 256));
         wait (pending_bytes.size() < 8);
      end
      wait (pending_bytes.size() == 0 && expected_codes.size() == 0);
      repeat (600) @(posedge clock);

      if (mismatches == 0 && expected_codes.size() == 0)
         $display("lzw_byte_compressor test passed");
      else
         $display("lzw_byte_compressor test failed");
      $finish;
   end

   initial begin
      #(12 * 2000000);
      $display("lzw_byte_compressor test failed");
      $finish;
   end

endmodule
